// File: rtl/core/c8ic_pkg.sv
package c8ic_pkg;

  localparam int MEMORY_BYTES_DEF  = 4096;
  localparam int SCREEN_WIDTH_DEF  = 64;
  localparam int SCREEN_HEIGHT_DEF = 32;
  localparam int STACK_DEPTH_DEF   = 16;

  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [11:0] PROGRAM_START_RST = 12'd512;
  localparam logic [7:0]  TIMER_RELOAD      = 8'd60;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] instruction;
    logic [15:0] index_register;
    logic [7:0]  flag_register;
    logic        sound_active;
    logic        screen_cleared;
    logic        key_wait;
    logic        invalid_instruction;
    logic [7:0]  read_data;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [3:0]  draw_rows;
  } result_t;

  // Decimal digits of a byte; narrow table-sized logic.
  function automatic logic [7:0] bcd_hundreds(input logic [7:0] v);
    bcd_hundreds = (v >= 8'd200) ? 8'd2 : (v >= 8'd100) ? 8'd1 : 8'd0;
  endfunction

  function automatic logic [7:0] bcd_rest(input logic [7:0] v);
    bcd_rest = (v >= 8'd200) ? v - 8'd200 : (v >= 8'd100) ? v - 8'd100 : v;
  endfunction

  function automatic logic [7:0] bcd_tens(input logic [7:0] r);
    logic [7:0] t;
    t = 8'd0;
    for (int k = 9; k >= 1; k--) begin
      if (t == 8'd0 && r >= 8'(k * 10)) begin
        t = 8'(k);
      end
    end
    bcd_tens = t;
  endfunction

endpackage

// File: rtl/core/c8ic_alu.sv
module c8ic_alu (
  input  logic [3:0] fn,
  input  logic [7:0] vx,
  input  logic [7:0] vy,
  output logic [7:0] res,
  output logic [7:0] flg,
  output logic       setf,
  output logic       bad
);
  always_comb begin
    res = 8'd0;
    flg = 8'd0;
    setf = 1'b1;
    bad = 1'b0;
    unique case (fn)
      4'h0: begin res = vy; setf = 1'b0; end
      4'h1: begin res = vx | vy; setf = 1'b0; end
      4'h2: begin res = vx & vy; setf = 1'b0; end
      4'h3: begin res = vx ^ vy; setf = 1'b0; end
      4'h4: begin
        res = vx + vy;
        flg = {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'd255};
      end
      4'h5: begin res = vx - vy; flg = {7'd0, vx >= vy}; end
      4'h6: begin res = {1'b0, vx[7:1]}; flg = {7'd0, vx[0]}; end
      4'h7: begin res = vy - vx; flg = {7'd0, vy >= vx}; end
      4'hE: begin res = {vx[6:0], 1'b0}; flg = {7'd0, vx[7]}; end
      default: begin setf = 1'b0; bad = 1'b1; end
    endcase
  end
endmodule

// File: rtl/core/chip8_instruction_core.sv
// CHIP-8 instruction core.
// Input channel: an item is accepted when start is high and busy is low.
// in_opcode selects executing one instruction, writing a memory byte, or
// reading a frame-buffer byte. Exactly one result item follows each item,
// shown for one cycle with out_valid high; the receiver cannot stall.
// cfg_we loads the program counter from cfg_wdata.
// After reset the core clears its frame buffer and registers one entry a
// cycle, with busy high; main memory and the return stack are not cleared.
// A memory write goes straight to S_DONE; a frame read passes S_FBR, S_FBR2.
// An instruction steps S_F0, S_F1, S_F2 and S_EXEC plus its memory loop: clear
// screen walks the frame buffer one byte a cycle, a sprite draw runs S_DRA,
// S_DRB, S_DRC and S_DRD per row and a last S_DRA, BCD writes three digits in
// S_BCD, a return adds S_RET, block store writes each register in S_ST, block
// load reads each in S_LDA then S_LDB. Single memory and frame-buffer ports set
// these steps. A new item is accepted only once the previous result has gone.
module chip8_instruction_core #(
  parameter int MEMORY_BYTES  = c8ic_pkg::MEMORY_BYTES_DEF,
  parameter int SCREEN_WIDTH  = c8ic_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = c8ic_pkg::SCREEN_HEIGHT_DEF,
  parameter int STACK_DEPTH   = c8ic_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [15:0] in_keys_down,
  input  logic [7:0]  in_random_byte,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  output logic        out_valid,
  output logic [11:0] out_program_counter,
  output logic [15:0] out_instruction,
  output logic [15:0] out_index_register,
  output logic [7:0]  out_flag_register,
  output logic        out_sound_active,
  output logic        out_screen_cleared,
  output logic        out_key_wait,
  output logic        out_invalid_instruction,
  output logic [7:0]  out_read_data,
  output logic [7:0]  out_draw_x,
  output logic [7:0]  out_draw_y,
  output logic [3:0]  out_draw_rows
);
  import c8ic_pkg::*;

  localparam int FB_BYTES  = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int ROW_BYTES = SCREEN_WIDTH / 8;
  localparam int FBW = $clog2(FB_BYTES);
  localparam int MW  = $clog2(MEMORY_BYTES);
  localparam int SPW = $clog2(STACK_DEPTH);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_F0     = 5'd2;
  localparam logic [4:0] S_F1     = 5'd3;
  localparam logic [4:0] S_F2     = 5'd4;
  localparam logic [4:0] S_EXEC   = 5'd5;
  localparam logic [4:0] S_RET    = 5'd6;
  localparam logic [4:0] S_CLS    = 5'd7;
  localparam logic [4:0] S_DRA    = 5'd8;
  localparam logic [4:0] S_DRB    = 5'd9;
  localparam logic [4:0] S_DRC    = 5'd10;
  localparam logic [4:0] S_DRD    = 5'd11;
  localparam logic [4:0] S_BCD    = 5'd12;
  localparam logic [4:0] S_ST     = 5'd13;
  localparam logic [4:0] S_LDA    = 5'd14;
  localparam logic [4:0] S_LDB    = 5'd15;
  localparam logic [4:0] S_FBR    = 5'd16;
  localparam logic [4:0] S_FBR2   = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;

  logic [7:0]  mem [MEMORY_BYTES];
  logic [7:0]  fb [FB_BYTES];
  logic [11:0] stk [STACK_DEPTH];
  logic [7:0]  v_r [16];

  logic [4:0]  st_r, st_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [15:0] i_r, i_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [7:0]  dt_r, dt_nxt, stm_r, stm_nxt;
  logic [15:0] w_r, w_nxt;
  logic [FBW-1:0] cnt_r, cnt_nxt;
  logic [4:0]  k_r, k_nxt;
  logic        hit_r, hit_nxt;
  logic [7:0]  spr_r, spr_nxt;
  logic [7:0]  b0v_r, b0v_nxt;
  logic [15:0] keys_r;
  logic [7:0]  rnd_r;
  logic        cls_r, cls_nxt, kw_r, kw_nxt, bad_r, bad_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic        dr_r, dr_nxt;
  logic [7:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic [3:0]  dn_r, dn_nxt;

  logic [MW-1:0] ma;
  logic          mwe;
  logic [7:0]    mwd, mrd_r;
  logic [FBW-1:0] fa;
  logic          fwe;
  logic [7:0]    fwd, frd_r;
  logic          vwe;
  logic [3:0]    vwa;
  logic [7:0]    vwd;
  logic          fwe15;
  logic [7:0]    fwd15;
  logic          swe;
  logic          tick;

  logic [3:0] xi, yi, nib;
  logic [7:0] vx, vy, imm8;
  logic [11:0] imm12;
  logic [7:0] ares, aflg;
  logic asetf, abad;
  logic [2:0] off;
  logic [7:0] lo, hi;
  logic [16:0] isum;
  logic [15:0] fbrow;
  logic [FBW-1:0] b0;
  logic [7:0] rem;

  assign xi = w_r[11:8];
  assign yi = w_r[7:4];
  assign nib = w_r[3:0];
  assign imm8 = w_r[7:0];
  assign imm12 = w_r[11:0];
  assign vx = v_r[xi];
  assign vy = v_r[yi];
  assign off = vx[2:0];
  assign lo = spr_r >> off;
  assign hi = 8'({spr_r, 8'd0} >> off);
  assign isum = {1'b0, i_r} + {9'd0, vx};
  assign fbrow = 16'({8'd0, vy} + {11'd0, k_r}) * 16'(ROW_BYTES);
  assign b0 = FBW'({8'd0, vx[7:3]} + fbrow);
  assign rem = bcd_rest(vx);

  c8ic_alu u_alu (
    .fn(nib), .vx(vx), .vy(vy), .res(ares), .flg(aflg), .setf(asetf), .bad(abad)
  );

  always_ff @(posedge clk) begin
    if (mwe) begin
      mem[ma] <= mwd;
    end
    mrd_r <= mem[ma];
    if (fwe) begin
      fb[fa] <= fwd;
    end
    frd_r <= fb[fa];
    if (swe) begin
      stk[sp_r] <= pc_r;
    end
  end

  always_comb begin
    st_nxt = st_r;
    pc_nxt = pc_r;
    i_nxt = i_r;
    sp_nxt = sp_r;
    dt_nxt = dt_r;
    stm_nxt = stm_r;
    w_nxt = w_r;
    cnt_nxt = cnt_r;
    k_nxt = k_r;
    hit_nxt = hit_r;
    spr_nxt = spr_r;
    b0v_nxt = b0v_r;
    cls_nxt = cls_r;
    kw_nxt = kw_r;
    bad_nxt = bad_r;
    rd_nxt = rd_r;
    dr_nxt = dr_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    dn_nxt = dn_r;
    ma = MW'(pc_r);
    mwe = 1'b0;
    mwd = 8'd0;
    fa = cnt_r;
    fwe = 1'b0;
    fwd = 8'd0;
    vwe = 1'b0;
    vwa = xi;
    vwd = 8'd0;
    fwe15 = 1'b0;
    fwd15 = 8'd0;
    swe = 1'b0;
    tick = 1'b0;
    unique case (st_r)
      S_CLR: begin
        fwe = 1'b1;
        vwe = 1'b1;
        vwa = cnt_r[3:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == FBW'(FB_BYTES - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          w_nxt = 16'd0;
          cls_nxt = 1'b0;
          kw_nxt = 1'b0;
          bad_nxt = 1'b0;
          rd_nxt = 8'd0;
          dr_nxt = 1'b0;
          dx_nxt = 8'd0;
          dy_nxt = 8'd0;
          dn_nxt = 4'd0;
          unique case (in_opcode)
            OP_EXEC: st_nxt = S_F0;
            OP_WRITE: begin
              ma = MW'(in_address);
              mwe = 1'b1;
              mwd = in_write_data;
              st_nxt = S_DONE;
            end
            OP_READ: begin
              cnt_nxt = FBW'(in_address % 12'(FB_BYTES));
              st_nxt = S_FBR;
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_FBR: st_nxt = S_FBR2;
      S_FBR2: begin
        rd_nxt = frd_r;
        st_nxt = S_DONE;
      end
      S_F0: begin
        st_nxt = S_F1;
      end
      S_F1: begin
        ma = MW'(pc_r + 12'd1);
        w_nxt = {mrd_r, 8'd0};
        st_nxt = S_F2;
      end
      S_F2: begin
        w_nxt = {w_r[15:8], mrd_r};
        pc_nxt = pc_r + 12'd2;
        st_nxt = S_EXEC;
      end
      S_EXEC: begin
        st_nxt = S_DONE;
        tick = 1'b1;
        unique case (w_r[15:12])
          4'h0: begin
            if (w_r == 16'h00E0) begin
              cls_nxt = 1'b1;
              cnt_nxt = '0;
              tick = 1'b0;
              st_nxt = S_CLS;
            end else if (w_r == 16'h00EE) begin
              sp_nxt = (sp_r == '0) ? SPW'(STACK_DEPTH - 1) : sp_r - 1'b1;
              tick = 1'b0;
              st_nxt = S_RET;
            end
          end
          4'h1: pc_nxt = imm12;
          4'h2: begin
            swe = 1'b1;
            sp_nxt = (sp_r == SPW'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
            pc_nxt = imm12;
          end
          4'h3: if (vx == imm8) pc_nxt = pc_r + 12'd2;
          4'h4: if (vx != imm8) pc_nxt = pc_r + 12'd2;
          4'h5: if (vx == vy) pc_nxt = pc_r + 12'd2;
          4'h6: begin vwe = 1'b1; vwd = imm8; end
          4'h7: begin vwe = 1'b1; vwd = vx + imm8; end
          4'h8: begin
            bad_nxt = abad;
            vwe = !abad;
            vwd = ares;
            fwe15 = asetf;
            fwd15 = aflg;
          end
          4'h9: if (vx != vy) pc_nxt = pc_r + 12'd2;
          4'hA: i_nxt = {4'd0, imm12};
          4'hB: pc_nxt = imm12 + {4'd0, v_r[0]};
          4'hC: begin vwe = 1'b1; vwd = rnd_r & imm8; end
          4'hD: begin
            dr_nxt = 1'b1;
            dx_nxt = vx;
            dy_nxt = vy;
            dn_nxt = nib;
            k_nxt = 5'd0;
            hit_nxt = 1'b0;
            tick = 1'b0;
            st_nxt = S_DRA;
          end
          4'hE: begin
            if (vx > 8'd15) begin
              bad_nxt = 1'b1;
            end else if (imm8 == 8'h9E) begin
              if (keys_r[vx[3:0]]) pc_nxt = pc_r + 12'd2;
            end else if (imm8 == 8'hA1) begin
              if (!keys_r[vx[3:0]]) pc_nxt = pc_r + 12'd2;
            end else begin
              bad_nxt = 1'b1;
            end
          end
          default: begin
            unique case (imm8)
              8'h07: begin vwe = 1'b1; vwd = dt_r; end
              8'h0A: kw_nxt = 1'b1;
              8'h15: dt_nxt = vx;
              8'h18: stm_nxt = vx;
              8'h1E: begin
                i_nxt = isum[15:0];
                fwe15 = 1'b1;
                fwd15 = {7'd0, isum > 17'h00FFF};
              end
              8'h29: i_nxt = {6'd0, vx, 2'b00} + {8'd0, vx};
              8'h33: begin
                k_nxt = 5'd0;
                tick = 1'b0;
                st_nxt = S_BCD;
              end
              8'h55: begin
                k_nxt = 5'd0;
                tick = 1'b0;
                st_nxt = S_ST;
              end
              8'h65: begin
                k_nxt = 5'd0;
                tick = 1'b0;
                st_nxt = S_LDA;
              end
              default: bad_nxt = 1'b1;
            endcase
          end
        endcase
      end
      S_RET: begin
        pc_nxt = stk[sp_r];
        tick = 1'b1;
        st_nxt = S_DONE;
      end
      S_CLS: begin
        fwe = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == FBW'(FB_BYTES - 1)) begin
          tick = 1'b1;
          st_nxt = S_DONE;
        end
      end
      S_DRA: begin
        if (k_r == {1'b0, nib}) begin
          fwe15 = 1'b1;
          fwd15 = {7'd0, hit_r};
          tick = 1'b1;
          st_nxt = S_DONE;
        end else begin
          ma = MW'(i_r + {11'd0, k_r});
          fa = b0;
          st_nxt = S_DRB;
        end
      end
      S_DRB: begin
        spr_nxt = mrd_r;
        b0v_nxt = frd_r;
        fa = b0 + 1'b1;
        st_nxt = S_DRC;
      end
      S_DRC: begin
        fa = b0;
        fwe = 1'b1;
        fwd = b0v_r ^ lo;
        if ((b0v_r & lo) != 8'd0) hit_nxt = 1'b1;
        b0v_nxt = frd_r;
        st_nxt = S_DRD;
      end
      S_DRD: begin
        fa = b0 + 1'b1;
        fwe = 1'b1;
        fwd = b0v_r ^ hi;
        if ((b0v_r & hi) != 8'd0) hit_nxt = 1'b1;
        k_nxt = k_r + 5'd1;
        st_nxt = S_DRA;
      end
      S_BCD: begin
        ma = MW'(i_r + {11'd0, k_r});
        mwe = 1'b1;
        unique case (k_r[1:0])
          2'd0: mwd = bcd_hundreds(vx);
          2'd1: mwd = bcd_tens(rem);
          default: mwd = rem - 8'({bcd_tens(rem), 3'b000} + {bcd_tens(rem), 1'b0});
        endcase
        k_nxt = k_r + 5'd1;
        if (k_r == 5'd2) begin
          tick = 1'b1;
          st_nxt = S_DONE;
        end
      end
      S_ST: begin
        ma = MW'(i_r + {11'd0, k_r});
        mwe = 1'b1;
        mwd = v_r[k_r[3:0]];
        k_nxt = k_r + 5'd1;
        if (k_r[3:0] == xi) begin
          tick = 1'b1;
          st_nxt = S_DONE;
        end
      end
      S_LDA: begin
        ma = MW'(i_r + {11'd0, k_r});
        st_nxt = S_LDB;
      end
      S_LDB: begin
        vwe = 1'b1;
        vwa = k_r[3:0];
        vwd = mrd_r;
        k_nxt = k_r + 5'd1;
        if (k_r[3:0] == xi) begin
          tick = 1'b1;
          st_nxt = S_DONE;
        end else begin
          st_nxt = S_LDA;
        end
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (tick) begin
      dt_nxt = (dt_nxt == 8'd0) ? TIMER_RELOAD : dt_nxt - 8'd1;
      stm_nxt = (stm_nxt == 8'd0) ? TIMER_RELOAD : stm_nxt - 8'd1;
    end
    if (cfg_we) begin
      pc_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      pc_r <= PROGRAM_START_RST;
      i_r <= 16'd0;
      sp_r <= '0;
      dt_r <= 8'd0;
      stm_r <= 8'd0;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      pc_r <= pc_nxt;
      i_r <= i_nxt;
      sp_r <= sp_nxt;
      dt_r <= dt_nxt;
      stm_r <= stm_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    k_r <= k_nxt;
    hit_r <= hit_nxt;
    spr_r <= spr_nxt;
    b0v_r <= b0v_nxt;
    cls_r <= cls_nxt;
    kw_r <= kw_nxt;
    bad_r <= bad_nxt;
    rd_r <= rd_nxt;
    dr_r <= dr_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    dn_r <= dn_nxt;
    if (st_r == S_IDLE && start) begin
      keys_r <= in_keys_down;
      rnd_r <= in_random_byte;
    end
    if (vwe) begin
      v_r[vwa] <= vwd;
    end
    if (fwe15) begin
      v_r[15] <= fwd15;
    end
  end

  result_t res;

  always_comb begin
    res.program_counter = pc_r;
    res.instruction = w_r;
    res.index_register = i_r;
    res.flag_register = v_r[15];
    res.sound_active = stm_r != 8'd0;
    res.screen_cleared = cls_r;
    res.key_wait = kw_r;
    res.invalid_instruction = bad_r;
    res.read_data = rd_r;
    res.draw_x = dr_r ? dx_r : 8'd0;
    res.draw_y = dr_r ? dy_r : 8'd0;
    res.draw_rows = dr_r ? dn_r : 4'd0;
  end

  assign busy = st_r != S_IDLE;
  assign out_valid = st_r == S_DONE;
  assign out_program_counter = res.program_counter;
  assign out_instruction = res.instruction;
  assign out_index_register = res.index_register;
  assign out_flag_register = res.flag_register;
  assign out_sound_active = res.sound_active;
  assign out_screen_cleared = res.screen_cleared;
  assign out_key_wait = res.key_wait;
  assign out_invalid_instruction = res.invalid_instruction;
  assign out_read_data = res.read_data;
  assign out_draw_x = res.draw_x;
  assign out_draw_y = res.draw_y;
  assign out_draw_rows = res.draw_rows;

endmodule
